[hw/rtl/depth_pixel_to_world_point_assert.svh]
// Assertion macros for the depth pixel to world point block.
// Used by the port checker; needs nothing else.
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_ASSERT_SVH

// Checks that an expression holds at every rising clock edge outside reset.
`define DPWP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("dpwp assertion failed");

// Checks that a consequence holds in the same cycle as its trigger.
`define DPWP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dpwp assertion failed");

`endif

[hw/rtl/dpwp_pkg.sv]
// Shared types, register codes and reset values for the depth pixel to world point block.
// Depends on nothing; every other SystemVerilog source file imports it.
package dpwp_pkg;

	// Default frame limit on column and row.
	localparam int unsigned DEF_MAX_DIMENSION = 4096;

	// Register stages from an accepted transaction to its result strobe.
	localparam int unsigned LATENCY = 8;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ROT_X     = 3'd0;
	localparam logic [2:0] CFG_ROT_Y     = 3'd1;
	localparam logic [2:0] CFG_ROT_Z     = 3'd2;
	localparam logic [2:0] CFG_TRANSLATE = 3'd3;
	localparam logic [2:0] CFG_PRINCIPAL = 3'd4;
	localparam logic [2:0] CFG_INV_FOCAL = 3'd5;

	// Reset values: identity rotation, no translation, default intrinsics.
	localparam logic [53:0] RST_ROT_X     = 54'h10_0000_0000_0000;
	localparam logic [53:0] RST_ROT_Y     = 54'h00_0004_0000_0000;
	localparam logic [53:0] RST_ROT_Z     = 54'h00_0000_0001_0000;
	localparam logic [62:0] RST_TRANSLATE = 63'h0;
	localparam logic [31:0] RST_PRINCIPAL = 32'h1458_0FD8;
	localparam logic [63:0] RST_INV_FOCAL = 64'h0000_7E84_0000_7E46;

	typedef struct packed {
		logic [11:0] column;
		logic [11:0] row;
		logic [15:0] depth_sample;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
	} pixel_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic [7:0]         out_blue;
		logic [7:0]         out_green;
		logic [7:0]         out_red;
	} point_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} colour_t;

	// Camera-frame point handed from back-projection to the pose transform.
	typedef struct packed {
		logic signed [40:0] cam_x;
		logic signed [40:0] cam_y;
		logic [15:0]        depth;
		colour_t            colour;
	} cam_t;

endpackage

[hw/rtl/dpwp_backproj.sv]
// Pinhole back-projection pipeline: pixel to camera-frame point in Q.8, four stages.
// Depends on dpwp_pkg.
module dpwp_backproj
	import dpwp_pkg::*;
#(
	parameter int unsigned MAX_DIMENSION = DEF_MAX_DIMENSION
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  pixel_t      pixel,
	input  logic [15:0] cx,
	input  logic [15:0] cy,
	input  logic [31:0] inv_fx,
	input  logic [31:0] inv_fy,
	output logic        cam_valid,
	output cam_t        cam
);

	logic [16:0] du, dv, du_neg, dv_neg;
	logic        keep;

	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        neg_x_s1, neg_y_s1, neg_x_s2, neg_y_s2, neg_x_s3, neg_y_s3;
	logic [15:0] mag_x_s1, mag_y_s1;
	logic [15:0] depth_s1, depth_s2, depth_s3;
	colour_t     colour_s1, colour_s2, colour_s3;
	logic [31:0] md_x_s2, md_y_s2;
	logic [63:0] p_x_s3, p_y_s3;
	cam_t        cam_s4;

	logic [64:0] rnd_x, rnd_y;
	logic [39:0] sat_x, sat_y;

	// Offsets from the principal point in Q.4, split into sign and magnitude.
	always_comb begin
		du     = {1'b0, pixel.column, 4'b0} - {1'b0, cx};
		dv     = {1'b0, pixel.row, 4'b0} - {1'b0, cy};
		du_neg = 17'(~du + 17'd1);
		dv_neg = 17'(~dv + 17'd1);
		keep   = in_valid && (pixel.depth_sample != 16'd0)
			&& (32'(pixel.column) < MAX_DIMENSION) && (32'(pixel.row) < MAX_DIMENSION);
	end

	// Rounding to Q.8 with halves away from zero, then magnitude saturation.
	always_comb begin
		rnd_x = {1'b0, p_x_s3} + 65'h8_0000;
		rnd_y = {1'b0, p_y_s3} + 65'h8_0000;
		sat_x = (|rnd_x[64:60]) ? 40'hFF_FFFF_FFFF : rnd_x[59:20];
		sat_y = (|rnd_y[64:60]) ? 40'hFF_FFFF_FFFF : rnd_y[59:20];
	end

	// Valid bits travel with the data; the pipeline never stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= keep;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload stages.
	always_ff @(posedge clk) begin
		// Stage one: offsets.
		neg_x_s1  <= du[16];
		neg_y_s1  <= dv[16];
		mag_x_s1  <= du[16] ? du_neg[15:0] : du[15:0];
		mag_y_s1  <= dv[16] ? dv_neg[15:0] : dv[15:0];
		depth_s1  <= pixel.depth_sample;
		colour_s1 <= '{blue: pixel.blue, green: pixel.green, red: pixel.red};
		// Stage two: offset times depth.
		md_x_s2   <= 32'(mag_x_s1) * 32'(depth_s1);
		md_y_s2   <= 32'(mag_y_s1) * 32'(depth_s1);
		neg_x_s2  <= neg_x_s1;
		neg_y_s2  <= neg_y_s1;
		depth_s2  <= depth_s1;
		colour_s2 <= colour_s1;
		// Stage three: times the inverse focal length.
		p_x_s3    <= 64'(md_x_s2) * 64'(inv_fx);
		p_y_s3    <= 64'(md_y_s2) * 64'(inv_fy);
		neg_x_s3  <= neg_x_s2;
		neg_y_s3  <= neg_y_s2;
		depth_s3  <= depth_s2;
		colour_s3 <= colour_s2;
		// Stage four: rounded and signed camera coordinates.
		cam_s4.cam_x  <= neg_x_s3 ? -$signed({1'b0, sat_x}) : $signed({1'b0, sat_x});
		cam_s4.cam_y  <= neg_y_s3 ? -$signed({1'b0, sat_y}) : $signed({1'b0, sat_y});
		cam_s4.depth  <= depth_s3;
		cam_s4.colour <= colour_s3;
	end

	assign cam_valid = valid_s4;
	assign cam       = cam_s4;

endmodule

[hw/rtl/dpwp_pose.sv]
// Rigid pose pipeline: rotation, translation, rounding and saturation, four stages.
// Depends on dpwp_pkg.
module dpwp_pose
	import dpwp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cam_valid,
	input  cam_t        cam,
	input  logic [53:0] rot_x,
	input  logic [53:0] rot_y,
	input  logic [53:0] rot_z,
	input  logic [62:0] translation,
	output logic        out_valid,
	output point_t      result
);

	logic [53:0]        rows [3];
	logic signed [17:0] rm [3][3];
	logic signed [20:0] tv [3];
	logic signed [16:0] hx, hy;
	logic signed [24:0] lx, ly;
	logic signed [16:0] dz;

	logic               valid_s5, valid_s6, valid_s7, valid_s8;
	colour_t            colour_s5, colour_s6, colour_s7;
	logic signed [34:0] p_hx_s5 [3];
	logic signed [34:0] p_hy_s5 [3];
	logic signed [42:0] p_lx_s5 [3];
	logic signed [42:0] p_ly_s5 [3];
	logic signed [34:0] p_z_s5 [3];
	logic signed [35:0] hi_s6 [3];
	logic signed [43:0] lo_s6 [3];
	logic signed [45:0] zt_s6 [3];
	logic signed [61:0] acc_s7 [3];
	logic signed [23:0] coord [3];
	point_t             result_s8;

	// Unpack the rotation entries and translation components.
	always_comb begin
		rows[0] = rot_x;
		rows[1] = rot_y;
		rows[2] = rot_z;
		for (int i = 0; i < 3; i++) begin
			tv[i] = $signed(translation[(2 - i) * 21 +: 21]);
			for (int j = 0; j < 3; j++) begin
				rm[i][j] = $signed(rows[i][(2 - j) * 18 +: 18]);
			end
		end
	end

	// Camera coordinates are split into a signed high part and an unsigned low part.
	always_comb begin
		hx = cam.cam_x[40:24];
		hy = cam.cam_y[40:24];
		lx = $signed({1'b0, cam.cam_x[23:0]});
		ly = $signed({1'b0, cam.cam_y[23:0]});
		dz = $signed({1'b0, cam.depth});
	end

	// The rounded value is an arithmetic shift; it saturates to 24 bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (acc_s7[i][61:47] == {15{acc_s7[i][61]}}) begin
				coord[i] = acc_s7[i][47:24];
			end else begin
				coord[i] = acc_s7[i][61] ? 24'sh80_0000 : 24'sh7F_FFFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else begin
			valid_s5 <= cam_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			// Stage five: partial products.
			p_hx_s5[i] <= rm[i][0] * hx;
			p_hy_s5[i] <= rm[i][1] * hy;
			p_lx_s5[i] <= rm[i][0] * lx;
			p_ly_s5[i] <= rm[i][1] * ly;
			p_z_s5[i]  <= rm[i][2] * dz;
			// Stage six: pair sums; depth term, translation and rounding half in Q.24.
			hi_s6[i] <= 36'(p_hx_s5[i]) + 36'(p_hy_s5[i]);
			lo_s6[i] <= 44'(p_lx_s5[i]) + 44'(p_ly_s5[i]);
			zt_s6[i] <= $signed({{3{p_z_s5[i][34]}}, p_z_s5[i], 8'b0})
				+ $signed({tv[i][20], tv[i], 24'b0}) + 46'sd8388608;
			// Stage seven: full Q.24 sum.
			acc_s7[i] <= $signed({{2{hi_s6[i][35]}}, hi_s6[i], 24'b0})
				+ $signed({{18{lo_s6[i][43]}}, lo_s6[i]})
				+ $signed({{16{zt_s6[i][45]}}, zt_s6[i]});
		end
		colour_s5 <= cam.colour;
		colour_s6 <= colour_s5;
		colour_s7 <= colour_s6;
		// Stage eight: output register.
		result_s8.point_x   <= coord[0];
		result_s8.point_y   <= coord[1];
		result_s8.point_z   <= coord[2];
		result_s8.out_blue  <= colour_s7.blue;
		result_s8.out_green <= colour_s7.green;
		result_s8.out_red   <= colour_s7.red;
	end

	assign out_valid = valid_s8;
	assign result    = result_s8;

endmodule

[hw/rtl/depth_pixel_to_world_point.sv]
// Top level of the depth pixel to world point block: configuration registers and pipeline.
// Depends on dpwp_pkg, dpwp_backproj and dpwp_pose.
//
//   Channel   Handshake                    Payload
//   input     start (busy is always low)   pixel   (pixel_t)
//   result    result_valid, one cycle      result  (point_t)
//   config    cfg_we                       cfg_index, cfg_data
//
// One transaction is accepted every cycle; a result appears once its transaction
// has passed the eight-stage multiply and add pipeline.
// Pixels with zero depth or outside the frame drop out and give no strobe.
// Reset clears the valid bits and loads the default pose and intrinsics.
// The receiver cannot stall, so the pipeline always advances.
module depth_pixel_to_world_point
	import dpwp_pkg::*;
#(
	parameter int unsigned MAX_DIMENSION = DEF_MAX_DIMENSION
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pixel_t      pixel,
	output logic        result_valid,
	output point_t      result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [53:0] rot_x_q, rot_y_q, rot_z_q;
	logic [62:0] translation_q;
	logic [31:0] principal_q;
	logic [63:0] inv_focal_q;
	logic        cam_valid;
	cam_t        cam;

	// The pipeline takes a new transaction in every cycle.
	assign busy = 1'b0;

	// Configuration registers; unused indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q       <= RST_ROT_X;
			rot_y_q       <= RST_ROT_Y;
			rot_z_q       <= RST_ROT_Z;
			translation_q <= RST_TRANSLATE;
			principal_q   <= RST_PRINCIPAL;
			inv_focal_q   <= RST_INV_FOCAL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROT_X:     rot_x_q       <= cfg_data[53:0];
				CFG_ROT_Y:     rot_y_q       <= cfg_data[53:0];
				CFG_ROT_Z:     rot_z_q       <= cfg_data[53:0];
				CFG_TRANSLATE: translation_q <= cfg_data[62:0];
				CFG_PRINCIPAL: principal_q   <= cfg_data[31:0];
				CFG_INV_FOCAL: inv_focal_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Back-projection into the camera frame.
	dpwp_backproj #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_backproj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pixel     (pixel),
		.cx        (principal_q[31:16]),
		.cy        (principal_q[15:0]),
		.inv_fx    (inv_focal_q[63:32]),
		.inv_fy    (inv_focal_q[31:0]),
		.cam_valid (cam_valid),
		.cam       (cam)
	);

	// Rotation and translation into the world frame.
	dpwp_pose u_pose (
		.clk         (clk),
		.arst_n      (arst_n),
		.cam_valid   (cam_valid),
		.cam         (cam),
		.rot_x       (rot_x_q),
		.rot_y       (rot_y_q),
		.rot_z       (rot_z_q),
		.translation (translation_q),
		.out_valid   (result_valid),
		.result      (result)
	);

endmodule

[hw/rtl/dpwp_checker.sv]
// Port checker for the depth pixel to world point block, bound to the top level.
// Depends on dpwp_pkg and depth_pixel_to_world_point_assert.svh.
`include "depth_pixel_to_world_point_assert.svh"

module dpwp_checker
	import dpwp_pkg::*;
#(
	parameter int unsigned MAX_DIMENSION = DEF_MAX_DIMENSION
) (
	input logic   clk,
	input logic   arst_n,
	input logic   start,
	input logic   busy,
	input pixel_t pixel,
	input logic   result_valid,
	input point_t result
);

	logic    exp_valid_q [LATENCY];
	colour_t exp_colour_q [LATENCY];
	logic    keep;
	logic    colour_match;

	// A transaction gives a result only with a measurement inside the frame.
	assign keep = start && !busy && (pixel.depth_sample != 16'd0)
		&& (32'(pixel.column) < MAX_DIMENSION) && (32'(pixel.row) < MAX_DIMENSION);

	// The colour on the result ports against the one that entered with the transaction.
	assign colour_match = (result.out_blue == exp_colour_q[LATENCY - 1].blue)
		&& (result.out_green == exp_colour_q[LATENCY - 1].green)
		&& (result.out_red == exp_colour_q[LATENCY - 1].red);

	// Expected strobes and colours, delayed by the pipeline latency.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LATENCY; i++) begin
				exp_valid_q[i] <= 1'b0;
			end
		end else begin
			exp_valid_q[0] <= keep;
			for (int i = 1; i < LATENCY; i++) begin
				exp_valid_q[i] <= exp_valid_q[i - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		exp_colour_q[0] <= '{blue: pixel.blue, green: pixel.green, red: pixel.red};
		for (int i = 1; i < LATENCY; i++) begin
			exp_colour_q[i] <= exp_colour_q[i - 1];
		end
	end

	`DPWP_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`DPWP_ASSERT_ALWAYS(a_strobe_matches, clk, arst_n, result_valid == exp_valid_q[LATENCY - 1])
	`DPWP_ASSERT_IMPLY(a_colour_follows, clk, arst_n, result_valid, colour_match)

endmodule

bind depth_pixel_to_world_point dpwp_checker #(
	.MAX_DIMENSION(MAX_DIMENSION)
) u_dpwp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.pixel        (pixel),
	.result_valid (result_valid),
	.result       (result)
);
